@@ design/bth_pkg.sv @@
// Package with the shared types, codes, constants and character tests of the token highlighter.
package bth_pkg;

   localparam int MaxResults        = 7;
   localparam int PlanCountWidth    = $clog2(MaxResults + 1);
   localparam int SlotIndexWidth    = $clog2(MaxResults);
   localparam int QueueDepthDefault = 2;
   localparam int RunDepth          = 3;

   typedef enum logic [2:0] {
      MODE_NORMAL  = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_STR     = 3'd2,
      MODE_STR_BS  = 3'd3,
      MODE_ESC     = 3'd4,
      MODE_ESC_X   = 3'd5,
      MODE_ESC_X1  = 3'd6,
      MODE_OPRUN   = 3'd7
   } bth_mode_type;

   typedef enum logic [2:0] {
      KIND_PLAIN   = 3'd0,
      KIND_COMMENT = 3'd1,
      KIND_STRING  = 3'd2,
      KIND_ESCAPE  = 3'd3,
      KIND_OPER    = 3'd4,
      KIND_RESET   = 3'd5
   } bth_kind_type;

   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_EQ     = 8'h3D;
   localparam logic [7:0] CHAR_BAR    = 8'h7C;
   localparam logic [7:0] CHAR_QMARK  = 8'h3F;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;

   typedef struct packed {
      logic       op;
      logic [7:0] byte_value;
   } bth_req_type;

   typedef struct packed {
      logic [2:0] out_kind;
      logic [7:0] out_byte;
      logic       last;
   } bth_rsp_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
   } bth_slot_type;

   typedef struct packed {
      bth_slot_type [MaxResults-1:0] slots;
      logic [PlanCountWidth-1:0]     count;
   } bth_plan_type;

   function automatic logic is_op_byte(input logic [7:0] c);
      logic result;
      case (c)
         8'h21, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E,
         8'h2F, 8'h3A, 8'h3D, 8'h3F, 8'h40, 8'h5E, 8'h5F, 8'h60, 8'h7C,
         8'h7E: result = 1'b1;
         default: result = 1'b0;
      endcase
      return result;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic bth_slot_type make_slot(input bth_kind_type kind,
                                              input logic [7:0] value);
      bth_slot_type slot;
      slot.kind  = kind;
      slot.value = (kind == KIND_PLAIN) ? value : 8'h00;
      return slot;
   endfunction

endpackage

@@ design/bth_lexer.sv @@
// Front end: accepts input transfers, runs the lexer state and builds the result plan of each item.
module bth_lexer import bth_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  bth_req_type  req_data,
   output logic         req_stall,
   input  logic         queue_full,
   output logic         plan_push,
   output bth_plan_type plan
);

   bth_mode_type mode_ff, mode_in;
   logic [7:0]   run_bytes_ff [RunDepth];
   logic [7:0]   run_bytes_in [RunDepth];
   logic [1:0]   run_len_ff, run_len_in;
   logic         run_ovf_ff, run_ovf_in;
   logic         accept;
   logic         run_match;
   logic [7:0]   c;

   assign c         = req_data.byte_value;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign plan_push = accept && (plan.count != '0);

   assign run_match =
      ((run_len_ff == 2'd1) &&
       (run_bytes_ff[0] == CHAR_BAR || run_bytes_ff[0] == CHAR_QMARK ||
        run_bytes_ff[0] == CHAR_STAR || run_bytes_ff[0] == CHAR_PLUS)) ||
      ((run_len_ff == 2'd3) && run_bytes_ff[0] == CHAR_COLON &&
       run_bytes_ff[1] == CHAR_COLON && run_bytes_ff[2] == CHAR_EQ);

   always_comb begin
      logic do_normal;
      mode_in      = mode_ff;
      run_bytes_in = run_bytes_ff;
      run_len_in   = run_len_ff;
      run_ovf_in   = run_ovf_ff;
      do_normal    = 1'b0;
      if (req_data.op == OP_END) begin
         if (mode_ff == MODE_OPRUN) begin
            run_len_in = 2'd0;
            run_ovf_in = 1'b0;
         end
         mode_in = MODE_NORMAL;
      end else begin
         case (mode_ff)
            MODE_NORMAL: do_normal = 1'b1;
            MODE_OPRUN: begin
               if (is_op_byte(c)) begin
                  if (!run_ovf_ff) begin
                     if (run_len_ff != 2'd3) begin
                        run_bytes_in[run_len_ff] = c;
                        run_len_in = run_len_ff + 2'd1;
                     end else begin
                        run_len_in = 2'd0;
                        run_ovf_in = 1'b1;
                     end
                  end
               end else begin
                  run_len_in = 2'd0;
                  run_ovf_in = 1'b0;
                  do_normal  = 1'b1;
               end
            end
            MODE_ESC: mode_in = (c == CHAR_X) ? MODE_ESC_X : MODE_NORMAL;
            MODE_ESC_X: begin
               if (is_hex(c)) begin
                  mode_in = MODE_ESC_X1;
               end else begin
                  do_normal = 1'b1;
               end
            end
            MODE_ESC_X1: begin
               if (is_hex(c)) begin
                  mode_in = MODE_NORMAL;
               end else begin
                  do_normal = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (c == CHAR_NL) begin
                  mode_in = MODE_NORMAL;
               end
            end
            MODE_STR: begin
               if (c == CHAR_QUOTE) begin
                  mode_in = MODE_NORMAL;
               end else if (c == CHAR_BSLASH) begin
                  mode_in = MODE_STR_BS;
               end
            end
            MODE_STR_BS: mode_in = MODE_STR;
            default: mode_in = MODE_NORMAL;
         endcase
         if (do_normal) begin
            if (c == CHAR_HASH || c == CHAR_SEMI) begin
               mode_in = MODE_COMMENT;
            end else if (c == CHAR_QUOTE) begin
               mode_in = MODE_STR;
            end else if (c == CHAR_BSLASH) begin
               mode_in = MODE_ESC;
            end else if (is_op_byte(c)) begin
               mode_in         = MODE_OPRUN;
               run_ovf_in      = 1'b0;
               run_bytes_in[0] = c;
               run_len_in      = 2'd1;
            end else begin
               mode_in = MODE_NORMAL;
            end
         end
      end
   end

   always_comb begin
      logic [PlanCountWidth-1:0] n;
      logic                      do_flush;
      logic                      do_normal;
      plan      = '0;
      n         = '0;
      do_flush  = 1'b0;
      do_normal = 1'b0;
      if (req_data.op == OP_END) begin
         if (mode_ff == MODE_OPRUN) begin
            do_flush = 1'b1;
         end else if (mode_ff != MODE_NORMAL) begin
            plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_RESET, 8'h00);
            n = n + 1'b1;
         end
      end else begin
         case (mode_ff)
            MODE_NORMAL: do_normal = 1'b1;
            MODE_OPRUN: begin
               if (is_op_byte(c)) begin
                  if (run_ovf_ff) begin
                     plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_PLAIN, c);
                     n = n + 1'b1;
                  end else if (run_len_ff == 2'd3) begin
                     for (int i = 0; i < RunDepth; i++) begin
                        plan.slots[n[SlotIndexWidth-1:0]] =
                           make_slot(KIND_PLAIN, run_bytes_ff[i]);
                        n = n + 1'b1;
                     end
                     plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_PLAIN, c);
                     n = n + 1'b1;
                  end
               end else begin
                  do_flush  = 1'b1;
                  do_normal = 1'b1;
               end
            end
            MODE_ESC: begin
               plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_PLAIN, c);
               n = n + 1'b1;
               if (c != CHAR_X) begin
                  plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_RESET, 8'h00);
                  n = n + 1'b1;
               end
            end
            MODE_ESC_X, MODE_ESC_X1: begin
               if (is_hex(c)) begin
                  plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_PLAIN, c);
                  n = n + 1'b1;
                  if (mode_ff == MODE_ESC_X1) begin
                     plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_RESET, 8'h00);
                     n = n + 1'b1;
                  end
               end else begin
                  plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_RESET, 8'h00);
                  n = n + 1'b1;
                  do_normal = 1'b1;
               end
            end
            MODE_COMMENT, MODE_STR: begin
               plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_PLAIN, c);
               n = n + 1'b1;
               if ((mode_ff == MODE_COMMENT && c == CHAR_NL) ||
                   (mode_ff == MODE_STR && c == CHAR_QUOTE)) begin
                  plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_RESET, 8'h00);
                  n = n + 1'b1;
               end
            end
            MODE_STR_BS: begin
               plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_PLAIN, c);
               n = n + 1'b1;
            end
            default: do_normal = 1'b0;
         endcase
      end
      if (do_flush && !run_ovf_ff) begin
         if (run_match) begin
            plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_OPER, 8'h00);
            n = n + 1'b1;
         end
         for (int i = 0; i < RunDepth; i++) begin
            if (2'(i) < run_len_ff) begin
               plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_PLAIN, run_bytes_ff[i]);
               n = n + 1'b1;
            end
         end
         if (run_match) begin
            plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_RESET, 8'h00);
            n = n + 1'b1;
         end
      end
      if (do_normal) begin
         if (c == CHAR_HASH || c == CHAR_SEMI) begin
            plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_COMMENT, 8'h00);
            n = n + 1'b1;
         end else if (c == CHAR_QUOTE) begin
            plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_STRING, 8'h00);
            n = n + 1'b1;
         end else if (c == CHAR_BSLASH) begin
            plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_ESCAPE, 8'h00);
            n = n + 1'b1;
         end
         if (!is_op_byte(c)) begin
            plan.slots[n[SlotIndexWidth-1:0]] = make_slot(KIND_PLAIN, c);
            n = n + 1'b1;
         end
      end
      plan.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         run_len_ff <= 2'd0;
         run_ovf_ff <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         run_len_ff <= run_len_in;
         run_ovf_ff <= run_ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         run_bytes_ff <= run_bytes_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_OPRUN && !run_ovf_ff) |-> (run_len_ff != 2'd0))
      else $error("operator run open without buffered bytes");

   assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_OPRUN) |-> (run_len_ff == 2'd0 && !run_ovf_ff))
      else $error("operator buffer left over outside a run");

endmodule

@@ design/bth_queue.sv @@
// Short queue of result plans between the lexer and the emitter.
module bth_queue import bth_pkg::*; #(
   parameter int DEPTH = QueueDepthDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  bth_plan_type push_data,
   output logic         full,
   input  logic         pop,
   output bth_plan_type head,
   output logic         empty
);

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   bth_plan_type          entries_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign full  = (count_ff == CountWidth'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("plan written into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("plan taken from an empty queue");

endmodule

@@ design/bth_emitter.sv @@
// Back end: walks the head plan one result per cycle into the registered result channel while rsp_stall is low.
module bth_emitter import bth_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  bth_plan_type head,
   input  logic         empty,
   output logic         pop,
   output logic         rsp_valid,
   output bth_rsp_type  rsp_data,
   input  logic         rsp_stall
);

   logic [SlotIndexWidth-1:0] idx_ff, idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   bth_rsp_type               rsp_data_ff, rsp_data_in;
   logic                      advance;
   logic                      is_last;
   bth_slot_type              slot;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign slot      = head.slots[idx_ff];
   assign is_last   = (PlanCountWidth'(idx_ff) + 1'b1 == head.count);
   assign pop       = advance && !empty && is_last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = !empty;
         if (!empty) begin
            rsp_data_in.out_kind = slot.kind;
            rsp_data_in.out_byte = slot.value;
            rsp_data_in.last     = is_last;
            idx_in               = is_last ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (head.count != '0 && PlanCountWidth'(idx_ff) < head.count))
      else $error("emitter index outside the head plan");

   assert property (@(posedge clock) disable iff (reset)
      empty |-> (idx_ff == '0))
      else $error("emitter index left over with no plan queued");

endmodule

@@ design/bnf_token_highlighter.sv @@
// Top level of the grammar text highlighter: lexer, plan queue and result emitter.
//
//   channel  direction  payload        transfer at a rising edge with
//   req_     in         bth_req_type   req_valid high and req_stall low
//   rsp_     out        bth_rsp_type   rsp_valid high and rsp_stall low
//
// An input transfer is taken while the plan queue has room; its results
// (up to seven) leave one per cycle from the emitter's output register while
// rsp_stall is low, and single-result items then flow at one per cycle.
// Synchronous reset empties the queue and returns the lexer to normal mode.
// A stalled result holds the emitter, and req_stall rises once the queue is full.
module bnf_token_highlighter import bth_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  bth_req_type req_data,
   output logic        req_stall,
   output logic        rsp_valid,
   output bth_rsp_type rsp_data,
   input  logic        rsp_stall
);

   bth_plan_type plan;
   bth_plan_type head;
   logic         plan_push;
   logic         queue_full;
   logic         queue_empty;
   logic         pop;

   bth_lexer u_lexer (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .queue_full (queue_full),
      .plan_push  (plan_push),
      .plan       (plan)
   );

   bth_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (plan_push),
      .push_data (plan),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty)
   );

   bth_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (queue_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
